### rtl/core/event_packet_centroid_velocity_defines.svh
// Assertion macros for the event packet centroid speed block.
`ifndef EVENT_PACKET_CENTROID_VELOCITY_DEFINES_SVH
`define EVENT_PACKET_CENTROID_VELOCITY_DEFINES_SVH

// check a property at every clock edge outside reset
`define EPCV_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check a property at every clock edge, reset included
`define EPCV_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/epcv_pkg.sv
// Package: constants, state and command types of the centroid speed block.
`default_nettype none
package epcv_pkg;

  localparam logic [16:0] MAX_PACKET_EVENTS = 17'd65536;
  localparam int          FRAC_BITS         = 8;
  localparam logic [19:0] US_PER_S          = 20'd1000000;
  localparam logic [47:0] MASK48            = 48'hFFFF_FFFF_FFFF;
  localparam logic [5:0]  DIV_STEPS         = 6'd48;
  localparam logic [5:0]  ROOT_STEPS        = 6'd25;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LD_COL,
    ST_DV_COL,
    ST_LD_ROW,
    ST_DV_ROW,
    ST_SQ_C,
    ST_SQ_R,
    ST_ROOT_LD,
    ST_ROOT,
    ST_SCALE,
    ST_LD_SPD,
    ST_DV_SPD,
    ST_DONE
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD_COL,
    OP_LOAD_ROW,
    OP_DIV_STEP,
    OP_SQ_C,
    OP_SQ_R,
    OP_ROOT_LOAD,
    OP_ROOT_STEP,
    OP_SCALE,
    OP_LOAD_SPD,
    OP_FINISH
  } dp_op_t;

  typedef struct packed {
    logic   accept;
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

### rtl/core/event_packet_centroid_velocity.sv
// Top level: event packet centroid speed block.
// Events enter on the evt channel (evt_valid / evt_stall), one per request.
// An event that is neither the packet end nor an empty-packet marker is
// added to the sums; the next event can be taken in the following cycle.
// A packet end starts the per-packet work: two centroid divisions of 48
// steps each on the shared restoring divider, squaring of both centroid
// differences, a 25-step square root, one scaling multiply and a 48-step
// speed division. The result leaves on the res channel (res_valid /
// res_stall). An empty-packet marker goes straight to the last step and
// gives its result from there. During the per-packet work evt_stall is high.
// The result register holds while res_stall is high; the block waits in its
// last step until the result register is free, so no result is lost.
// rst is synchronous: it clears sums, counts, previous centroid and time,
// the event total and the result valid flag.
`default_nettype none
module event_packet_centroid_velocity (
  input  wire         clk,
  input  wire         rst,
  input  wire         evt_valid,
  output logic        evt_stall,
  input  wire  [15:0] pos_x,
  input  wire  [15:0] pos_y,
  input  wire  [63:0] time_us,
  input  wire         end_of_packet,
  input  wire         empty_packet,
  output logic        res_valid,
  input  wire         res_stall,
  output logic [47:0] speed_q8,
  output logic [47:0] total_events,
  output logic        packet_overflow
);
  import epcv_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  epcv_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .evt_valid     (evt_valid),
    .end_of_packet (end_of_packet),
    .empty_packet  (empty_packet),
    .stat          (stat),
    .evt_stall     (evt_stall),
    .cmd           (cmd)
  );

  epcv_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .pos_x           (pos_x),
    .pos_y           (pos_y),
    .time_us         (time_us),
    .empty_packet    (empty_packet),
    .res_stall       (res_stall),
    .stat            (stat),
    .res_valid       (res_valid),
    .speed_q8        (speed_q8),
    .total_events    (total_events),
    .packet_overflow (packet_overflow)
  );

endmodule
`default_nettype wire

### rtl/core/epcv_ctrl.sv
// Controller: sequences accumulation, divisions, root and result handoff.
`default_nettype none
module epcv_ctrl (
  input  wire                clk,
  input  wire                rst,
  input  wire                evt_valid,
  input  wire                end_of_packet,
  input  wire                empty_packet,
  input  epcv_pkg::dp_stat_t stat,
  output logic               evt_stall,
  output epcv_pkg::dp_cmd_t  cmd
);
  import epcv_pkg::*;

  state_t     state, state_next;
  logic [5:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = '0;
    evt_stall  = 1'b1;
    cmd.accept = 1'b0;
    cmd.op     = OP_NONE;
    case (state)
      ST_IDLE: begin
        evt_stall = 1'b0;
        if (evt_valid) begin
          cmd.accept = 1'b1;
          if (empty_packet) state_next = ST_DONE;
          else if (end_of_packet) state_next = ST_LD_COL;
        end
      end
      ST_LD_COL: begin
        cmd.op = OP_LOAD_COL;
        state_next = ST_DV_COL;
      end
      ST_DV_COL: begin
        cmd.op = OP_DIV_STEP;
        cnt_next = cnt + 6'd1;
        if (cnt == DIV_STEPS - 6'd1) begin
          cnt_next = '0;
          state_next = ST_LD_ROW;
        end
      end
      ST_LD_ROW: begin
        cmd.op = OP_LOAD_ROW;
        state_next = ST_DV_ROW;
      end
      ST_DV_ROW: begin
        cmd.op = OP_DIV_STEP;
        cnt_next = cnt + 6'd1;
        if (cnt == DIV_STEPS - 6'd1) begin
          cnt_next = '0;
          state_next = ST_SQ_C;
        end
      end
      ST_SQ_C: begin
        cmd.op = OP_SQ_C;
        state_next = ST_SQ_R;
      end
      ST_SQ_R: begin
        cmd.op = OP_SQ_R;
        state_next = ST_ROOT_LD;
      end
      ST_ROOT_LD: begin
        cmd.op = OP_ROOT_LOAD;
        state_next = ST_ROOT;
      end
      ST_ROOT: begin
        cmd.op = OP_ROOT_STEP;
        cnt_next = cnt + 6'd1;
        if (cnt == ROOT_STEPS - 6'd1) begin
          cnt_next = '0;
          state_next = ST_SCALE;
        end
      end
      ST_SCALE: begin
        cmd.op = OP_SCALE;
        state_next = ST_LD_SPD;
      end
      ST_LD_SPD: begin
        cmd.op = OP_LOAD_SPD;
        state_next = ST_DV_SPD;
      end
      ST_DV_SPD: begin
        cmd.op = OP_DIV_STEP;
        cnt_next = cnt + 6'd1;
        if (cnt == DIV_STEPS - 6'd1) begin
          cnt_next = '0;
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (stat.out_free) begin
          cmd.op = OP_FINISH;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

### rtl/core/epcv_dp.sv
// Datapath: packet sums, shared divider, square root and result register.
`default_nettype none
module epcv_dp (
  input  wire               clk,
  input  wire               rst,
  input  epcv_pkg::dp_cmd_t cmd,
  input  wire        [15:0] pos_x,
  input  wire        [15:0] pos_y,
  input  wire        [63:0] time_us,
  input  wire               empty_packet,
  input  wire               res_stall,
  output epcv_pkg::dp_stat_t stat,
  output logic              res_valid,
  output logic       [47:0] speed_q8,
  output logic       [47:0] total_events,
  output logic              packet_overflow
);
  import epcv_pkg::*;

  logic [31:0] sum_col, sum_row;
  logic [16:0] packet_count;
  logic [63:0] packet_last_time, prev_time;
  logic [23:0] prev_centroid_col, prev_centroid_row, ccol, crow;
  logic [47:0] event_total;
  logic        dropped, item_empty, spd_ok;

  logic [63:0] dv_rem, dv_den;
  logic [47:0] dv_quo;
  logic [48:0] sq_acc;
  logic [49:0] rt_op, rt_res, rt_one;
  logic [44:0] prod;

  logic [64:0] dv_trial;
  logic        dv_ge;
  logic [49:0] rt_t;
  logic [23:0] dc, dr;
  logic [47:0] dc_sq, dr_sq;
  logic [63:0] gap;
  logic [48:0] total_sum;
  logic [47:0] total_new;

  assign dv_trial  = {dv_rem, dv_quo[47]};
  assign dv_ge     = dv_trial >= {1'b0, dv_den};
  assign rt_t      = rt_res + rt_one;
  assign dc        = (ccol >= prev_centroid_col) ? ccol - prev_centroid_col
                                                 : prev_centroid_col - ccol;
  assign dr        = (crow >= prev_centroid_row) ? crow - prev_centroid_row
                                                 : prev_centroid_row - crow;
  assign dc_sq     = dc * dc;
  assign dr_sq     = dr * dr;
  assign gap       = packet_last_time - prev_time;
  assign total_sum = {1'b0, event_total} + {32'd0, packet_count};
  assign total_new = (total_sum > {1'b0, MASK48}) ? MASK48 : total_sum[47:0];
  assign stat.out_free = !res_valid || !res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_col           <= '0;
      sum_row           <= '0;
      packet_count      <= '0;
      packet_last_time  <= '0;
      prev_centroid_col <= '0;
      prev_centroid_row <= '0;
      prev_time         <= '0;
      event_total       <= '0;
      dropped           <= 1'b0;
      item_empty        <= 1'b0;
      res_valid         <= 1'b0;
    end else begin
      if (cmd.op == OP_FINISH) res_valid <= 1'b1;
      else if (!res_stall) res_valid <= 1'b0;
      if (cmd.accept) begin
        item_empty <= empty_packet;
        if (!empty_packet) begin
          if (packet_count < MAX_PACKET_EVENTS) begin
            sum_col      <= sum_col + {16'd0, pos_x};
            sum_row      <= sum_row + {16'd0, pos_y};
            packet_count <= packet_count + 17'd1;
          end else begin
            dropped <= 1'b1;
          end
          packet_last_time <= time_us;
        end
      end
      if (cmd.op == OP_FINISH) begin
        if (item_empty) begin
          speed_q8        <= '0;
          total_events    <= event_total;
          packet_overflow <= 1'b0;
        end else begin
          speed_q8          <= spd_ok ? dv_quo : '0;
          total_events      <= total_new;
          packet_overflow   <= dropped;
          event_total       <= total_new;
          prev_centroid_col <= ccol;
          prev_centroid_row <= crow;
          prev_time         <= packet_last_time;
          sum_col           <= '0;
          sum_row           <= '0;
          packet_count      <= '0;
          dropped           <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD_COL: begin
        dv_rem <= '0;
        dv_den <= {47'd0, packet_count};
        dv_quo <= {8'd0, sum_col, 8'd0} + {32'd0, packet_count[16:1]};
      end
      OP_LOAD_ROW: begin
        ccol   <= dv_quo[23:0];
        dv_rem <= '0;
        dv_den <= {47'd0, packet_count};
        dv_quo <= {8'd0, sum_row, 8'd0} + {32'd0, packet_count[16:1]};
      end
      OP_DIV_STEP: begin
        dv_rem <= dv_ge ? 64'(dv_trial - {1'b0, dv_den}) : dv_trial[63:0];
        dv_quo <= {dv_quo[46:0], dv_ge};
      end
      OP_SQ_C: begin
        crow   <= dv_quo[23:0];
        sq_acc <= {1'b0, dc_sq};
      end
      OP_SQ_R: sq_acc <= sq_acc + {1'b0, dr_sq};
      OP_ROOT_LOAD: begin
        rt_op  <= {1'b0, sq_acc};
        rt_res <= '0;
        rt_one <= 50'd1 << 48;
      end
      OP_ROOT_STEP: begin
        if (rt_op >= rt_t) begin
          rt_op  <= rt_op - rt_t;
          rt_res <= (rt_res >> 1) + rt_one;
        end else begin
          rt_res <= rt_res >> 1;
        end
        rt_one <= rt_one >> 2;
      end
      OP_SCALE: prod <= rt_res[24:0] * US_PER_S;
      OP_LOAD_SPD: begin
        spd_ok <= (event_total != '0) && (packet_last_time > prev_time) &&
                  (gap > 64'd1);
        dv_rem <= '0;
        dv_den <= gap;
        dv_quo <= {3'd0, prod};
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

### rtl/core/epcv_checker.sv
// Checker: port-level assertions for the centroid speed block, with bind.
`default_nettype none
`include "event_packet_centroid_velocity_defines.svh"
module epcv_checker (
  input wire        clk,
  input wire        rst,
  input wire        evt_valid,
  input wire        evt_stall,
  input wire        end_of_packet,
  input wire        empty_packet,
  input wire        res_valid,
  input wire        res_stall,
  input wire [47:0] speed_q8,
  input wire [47:0] total_events,
  input wire        packet_overflow
);

  `EPCV_ASSERT(a_res_hold, clk, rst, res_valid && res_stall |=> res_valid && $stable(speed_q8) && $stable(total_events), "stalled result changed")
  `EPCV_ASSERT(a_zero_total, clk, rst, res_valid && total_events == 48'd0 |-> speed_q8 == 48'd0 && !packet_overflow, "speed or overflow without events")
  `EPCV_ASSERT(a_busy_after_end, clk, rst, evt_valid && !evt_stall && (end_of_packet || empty_packet) |=> evt_stall, "request taken while packet in work")
  `EPCV_ASSERT_ALWAYS(a_reset_clear, clk, $past(rst) |-> !res_valid, "result valid after reset")

endmodule

bind event_packet_centroid_velocity epcv_checker u_checker (
  .clk             (clk),
  .rst             (rst),
  .evt_valid       (evt_valid),
  .evt_stall       (evt_stall),
  .end_of_packet   (end_of_packet),
  .empty_packet    (empty_packet),
  .res_valid       (res_valid),
  .res_stall       (res_stall),
  .speed_q8        (speed_q8),
  .total_events    (total_events),
  .packet_overflow (packet_overflow)
);
`default_nettype wire
